@@ sv/pcbp_pkg.sv @@
// ----------------------------------------------------------------------------
// pcbp_pkg
// Shared types, constants and the character to symbol map of the bit packer.
// ----------------------------------------------------------------------------
package pcbp_pkg;

  localparam int MAX_CODE_BITS = 32;
  localparam int SYMBOL_COUNT  = 36;
  localparam int CODE_W        = 32;
  localparam int ZERO_W        = 6;
  localparam int ENTRY_W       = CODE_W + ZERO_W;
  localparam int SYM_W         = $clog2(SYMBOL_COUNT);
  localparam int EMIT_W        = $clog2(MAX_CODE_BITS + 1);
  localparam int DIGIT_W       = $clog2(CODE_W + 1);

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FLUSH  = 2'd2;

  // one bit or a flush request from the sequencer to the packer
  typedef struct packed {
    logic valid;
    logic data;
    logic flush;
  } push_t;

  typedef struct packed {
    logic             hit;
    logic [SYM_W-1:0] idx;
  } sym_t;

  // digits map to 0..9, letters of either case to 10..35
  function automatic sym_t sym_lookup(input logic [7:0] c);
    sym_t s;
    s.hit = 1'b0;
    s.idx = '0;
    if (c >= 8'd48 && c <= 8'd57) begin
      s.hit = 1'b1;
      s.idx = SYM_W'(c - 8'd48);
    end else if (c >= 8'd65 && c <= 8'd90) begin
      s.hit = 1'b1;
      s.idx = SYM_W'(c - 8'd65 + 8'd9 + 8'd1);
    end else if (c >= 8'd97 && c <= 8'd122) begin
      s.hit = 1'b1;
      s.idx = SYM_W'(c - 8'd97 + 8'd9 + 8'd1);
    end
    return s;
  endfunction

endpackage

@@ sv/pcbp_ifs.sv @@
// ----------------------------------------------------------------------------
// pcbp_ifs
// Valid/ready channels for input items and packed output bytes.
// ----------------------------------------------------------------------------
interface pcbp_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  char_in;
  logic [31:0] code_value;
  logic [5:0]  zero_count;

  modport source (output valid, mode, char_in, code_value, zero_count, input ready);
  modport sink   (input valid, mode, char_in, code_value, zero_count, output ready);
endinterface

interface pcbp_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, out_byte, last, input ready);
  modport sink   (input valid, out_byte, last, output ready);
endinterface

@@ sv/pcbp_ram.sv @@
// ----------------------------------------------------------------------------
// pcbp_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module pcbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ sv/pcbp_packer.sv @@
// ----------------------------------------------------------------------------
// pcbp_packer
// Packs single bits MSB first into bytes and holds the output register.
// ----------------------------------------------------------------------------
module pcbp_packer
  import pcbp_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  push_t             push,
  output logic              push_ready,
  pcbp_out_if.source        out_ch
);

  logic [7:0]  pending;
  logic [3:0]  bits_held;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        last;
  logic        slot_free;
  logic        full;
  logic [7:0]  aligned;

  assign slot_free  = !out_valid || out_ch.ready;
  assign full       = (bits_held == 4'd8);
  assign push_ready = push.flush ? slot_free : (!full || slot_free);
  // left-align the partial byte, nothing held gives zero
  assign aligned    = pending << (4'd8 - bits_held);

  assign out_ch.valid    = out_valid;
  assign out_ch.out_byte = out_byte;
  assign out_ch.last     = last;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending   <= '0;
      bits_held <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (push.valid && push_ready) begin
        if (push.flush) begin
          out_byte  <= aligned;
          last      <= 1'b1;
          out_valid <= 1'b1;
          pending   <= '0;
          bits_held <= '0;
        end else if (full) begin
          out_byte  <= pending;
          last      <= 1'b0;
          out_valid <= 1'b1;
          pending   <= {7'b0, push.data};
          bits_held <= 4'd1;
        end else begin
          pending   <= {pending[6:0], push.data};
          bits_held <= bits_held + 4'd1;
        end
      end
    end
  end

endmodule

@@ sv/pcbp_emitter.sv @@
// ----------------------------------------------------------------------------
// pcbp_emitter
// Code table and bit-serial sequencer: zero bits, leading-zero skip, digits.
// ----------------------------------------------------------------------------
module pcbp_emitter
  import pcbp_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  pcbp_in_if.sink       in_ch,
  output push_t         push,
  input  logic          push_ready
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_READ  = 6'b000010,
    ST_ZERO  = 6'b000100,
    ST_SKIP  = 6'b001000,
    ST_DIGIT = 6'b010000,
    ST_FLUSH = 6'b100000
  } state_t;

  state_t              state;
  sym_t                sym;
  logic                accept;
  logic                we;
  logic [ENTRY_W-1:0]  rdata;
  logic [SYMBOL_COUNT-1:0] tbl_valid;
  logic                rd_valid;
  logic [CODE_W-1:0]   val_sr;
  logic [ZERO_W-1:0]   zleft;
  logic [EMIT_W-1:0]   emitted;
  logic [DIGIT_W-1:0]  remain;
  logic                at_max;

  assign sym         = sym_lookup(in_ch.char_in);
  assign in_ch.ready = (state == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign we          = accept && (in_ch.mode == MODE_LOAD) && sym.hit;
  assign at_max      = (emitted == EMIT_W'(MAX_CODE_BITS));

  pcbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (sym.idx),
    .wdata ({in_ch.zero_count, in_ch.code_value}),
    .raddr (sym.idx),
    .rdata (rdata)
  );

  always_comb begin
    push.valid = 1'b0;
    push.data  = 1'b0;
    push.flush = 1'b0;
    case (state)
      ST_ZERO: begin
        push.valid = !at_max && (zleft != '0);
      end
      ST_DIGIT: begin
        push.valid = !at_max && (remain != '0);
        push.data  = val_sr[CODE_W-1];
      end
      ST_FLUSH: begin
        push.valid = 1'b1;
        push.flush = 1'b1;
      end
      default: begin
        push.valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      tbl_valid <= '0;
    end else begin
      if (we) begin
        tbl_valid[sym.idx] <= 1'b1;
      end
      case (state)
        ST_IDLE: begin
          rd_valid <= tbl_valid[sym.idx];
          if (accept && in_ch.mode == MODE_ENCODE && sym.hit) begin
            state <= ST_READ;
          end else if (accept && in_ch.mode == MODE_FLUSH) begin
            state <= ST_FLUSH;
          end
        end
        ST_READ: begin
          // entries never loaded read as zero
          val_sr  <= rd_valid ? rdata[CODE_W-1:0] : '0;
          zleft   <= rd_valid ? rdata[ENTRY_W-1:CODE_W] : '0;
          emitted <= '0;
          remain  <= DIGIT_W'(CODE_W);
          state   <= ST_ZERO;
        end
        ST_ZERO: begin
          if (at_max) begin
            state <= ST_IDLE;
          end else if (zleft == '0) begin
            state <= ST_SKIP;
          end else if (push_ready) begin
            zleft   <= zleft - 1'b1;
            emitted <= emitted + 1'b1;
          end
        end
        ST_SKIP: begin
          // shift out leading zeros of the code value without emitting
          if (val_sr == '0) begin
            state <= ST_IDLE;
          end else if (val_sr[CODE_W-1]) begin
            state <= ST_DIGIT;
          end else begin
            val_sr <= {val_sr[CODE_W-2:0], 1'b0};
            remain <= remain - 1'b1;
          end
        end
        ST_DIGIT: begin
          if (at_max || remain == '0) begin
            state <= ST_IDLE;
          end else if (push_ready) begin
            val_sr  <= {val_sr[CODE_W-2:0], 1'b0};
            remain  <= remain - 1'b1;
            emitted <= emitted + 1'b1;
          end
        end
        ST_FLUSH: begin
          if (push_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ sv/prefix_code_bit_packer_top.sv @@
// ----------------------------------------------------------------------------
// prefix_code_bit_packer_top
// Prefix-code emitter that packs code bits MSB first into bytes.
//
//   channel  dir  fields                                   beat
//   in_ch    in   mode, char_in, code_value, zero_count    one item
//   out_ch   out  out_byte, last                           one packed byte
//
// An encode reads its table entry, emits the zero bits, skips the leading
// zeros of the code value and emits its digits (none for a zero code
// value), one bit a cycle through the serial shifter while the packer
// takes it; once MAX_CODE_BITS bits are out the sequencer returns to idle.
// Reset clears the table valid bits, the packer's held bits and the output
// valid flag. A stalled output holds the shifter when a full byte must leave
// and holds a flush until the output register frees.
// ----------------------------------------------------------------------------
module prefix_code_bit_packer_top
  import pcbp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  pcbp_in_if.sink     in_ch,
  pcbp_out_if.source  out_ch
);

  push_t push;
  logic  push_ready;

  pcbp_emitter u_emitter (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .push       (push),
    .push_ready (push_ready)
  );

  pcbp_packer u_packer (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .out_ch     (out_ch)
  );

endmodule
